// File: rtl/nec_ir_frame_decoder_assert.svh
// Assertion macros used by the decoder core.
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define NECIR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("necir assertion failed");

// Next-cycle implication, disabled while reset is high.
`define NECIR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("necir assertion failed");

`endif

// File: rtl/necir_pkg.sv
package necir_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_LEADER_MIN = 3'd0;
   localparam logic [2:0] CSR_LEADER_MAX = 3'd1;
   localparam logic [2:0] CSR_ZERO_MIN   = 3'd2;
   localparam logic [2:0] CSR_ZERO_MAX   = 3'd3;
   localparam logic [2:0] CSR_ONE_MIN    = 3'd4;
   localparam logic [2:0] CSR_ONE_MAX    = 3'd5;

   // Threshold defaults in timer ticks
   localparam logic [15:0] LEADER_MIN_RESET = 16'd24000;
   localparam logic [15:0] LEADER_MAX_RESET = 16'd29000;
   localparam logic [15:0] ZERO_MIN_RESET   = 16'd2000;
   localparam logic [15:0] ZERO_MAX_RESET   = 16'd3000;
   localparam logic [15:0] ONE_MIN_RESET    = 16'd4000;
   localparam logic [15:0] ONE_MAX_RESET    = 16'd5000;

   // Request action codes
   localparam logic ACT_EDGE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INV_FAIL  = 2'd1,
      ST_BAD_PULSE = 2'd2,
      ST_TIMEOUT   = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_ADDR   = 5'b00010,
      PH_ADDR_N = 5'b00100,
      PH_CMD    = 5'b01000,
      PH_CMD_N  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [15:0] leader_min;
      logic [15:0] leader_max;
      logic [15:0] zero_min;
      logic [15:0] zero_max;
      logic [15:0] one_min;
      logic [15:0] one_max;
   } cfg_type;

   typedef struct packed {
      logic leader;
      logic zero;
      logic one;
   } pulse_type;

endpackage

// File: rtl/necir_csr.sv
module necir_csr import necir_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LEADER_MIN: cfg_in.leader_min = csr_data;
            CSR_LEADER_MAX: cfg_in.leader_max = csr_data;
            CSR_ZERO_MIN:   cfg_in.zero_min   = csr_data;
            CSR_ZERO_MAX:   cfg_in.zero_max   = csr_data;
            CSR_ONE_MIN:    cfg_in.one_min    = csr_data;
            CSR_ONE_MAX:    cfg_in.one_max    = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_min <= LEADER_MIN_RESET;
         cfg_ff.leader_max <= LEADER_MAX_RESET;
         cfg_ff.zero_min   <= ZERO_MIN_RESET;
         cfg_ff.zero_max   <= ZERO_MAX_RESET;
         cfg_ff.one_min    <= ONE_MIN_RESET;
         cfg_ff.one_max    <= ONE_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/necir_classify.sv
module necir_classify import necir_pkg::*; (
   input  cfg_type     cfg,
   input  logic [15:0] now_time,
   input  logic [15:0] prev_time,
   output pulse_type   pulse
);

   logic [15:0] period;

   // Wrapping difference between two captures
   assign period = now_time - prev_time;

   // Window compares
   assign pulse.leader = (period > cfg.leader_min) && (period < cfg.leader_max);
   assign pulse.zero   = (period >= cfg.zero_min) && (period <= cfg.zero_max);
   assign pulse.one    = (period >= cfg.one_min) && (period <= cfg.one_max);

endmodule

// File: rtl/necir_core.sv
`include "nec_ir_frame_decoder_assert.svh"

module necir_core import necir_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        stage_valid,
   input  logic        stage_action,
   input  logic [15:0] stage_time,
   output logic        stage_go,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_address,
   output logic [7:0]  rsp_command
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] bits_ff, bits_in;
   logic [15:0] prev_time_ff, prev_time_in;
   logic        prev_valid_ff, prev_valid_in;
   logic        armed_ff, armed_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff;
   logic [7:0]  rsp_address_ff;
   logic [7:0]  rsp_command_ff;

   logic        fire;
   logic        active;
   logic        emit;
   status_type  emit_status;
   logic [7:0]  emit_address;
   logic [7:0]  emit_command;
   logic [31:0] bits_shift;
   pulse_type   pulse;

   necir_classify u_classify (
      .cfg       (cfg),
      .now_time  (stage_time),
      .prev_time (prev_time_ff),
      .pulse     (pulse)
   );

   // The stage moves on when the result register is free or draining
   assign stage_go = !rsp_valid_ff || !rsp_stall;
   assign fire     = stage_valid && stage_go;
   assign active   = (phase_ff != PH_IDLE);

   // Bits arrive LSB first: shift in at the top; zero window wins on overlap
   assign bits_shift = {pulse.one && !pulse.zero, bits_ff[31:1]};

   // Frame state update for one request
   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      bits_in       = bits_ff;
      prev_time_in  = prev_time_ff;
      prev_valid_in = prev_valid_ff;
      armed_in      = armed_ff;
      emit          = 1'b0;
      emit_status   = ST_OK;
      emit_address  = 8'd0;
      emit_command  = 8'd0;
      if (fire) begin
         if (stage_action == ACT_TICK) begin
            if (armed_ff) begin
               prev_valid_in = 1'b0;
               phase_in      = PH_IDLE;
               armed_in      = 1'b0;
               emit          = 1'b1;
               emit_status   = ST_TIMEOUT;
            end else if (active) begin
               armed_in = 1'b1;
            end
         end else begin
            armed_in     = 1'b0;
            prev_time_in = stage_time;
            if (!prev_valid_ff) begin
               prev_valid_in = 1'b1;
            end else if (pulse.leader) begin
               phase_in = PH_ADDR;
               count_in = 3'd0;
               bits_in  = 32'd0;
            end else if (pulse.zero || pulse.one) begin
               if (active) begin
                  bits_in  = bits_shift;
                  count_in = count_ff + 3'd1;
                  if (count_ff == 3'd7) begin
                     case (phase_ff)
                        PH_ADDR:   phase_in = PH_ADDR_N;
                        PH_ADDR_N: phase_in = PH_CMD;
                        PH_CMD:    phase_in = PH_CMD_N;
                        PH_CMD_N: begin
                           phase_in      = PH_IDLE;
                           prev_valid_in = 1'b0;
                           emit          = 1'b1;
                           emit_address  = bits_shift[7:0];
                           emit_command  = bits_shift[23:16];
                           if ((bits_shift[7:0] == ~bits_shift[15:8]) &&
                               (bits_shift[23:16] == ~bits_shift[31:24])) begin
                              emit_status = ST_OK;
                           end else begin
                              emit_status = ST_INV_FAIL;
                           end
                        end
                        default:   phase_in = PH_IDLE;
                     endcase
                  end
               end
            end else begin
               phase_in      = PH_IDLE;
               prev_valid_in = 1'b0;
               if (active) begin
                  emit        = 1'b1;
                  emit_status = ST_BAD_PULSE;
               end
            end
         end
      end
   end

   // Result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         count_ff      <= 3'd0;
         bits_ff       <= 32'd0;
         prev_time_ff  <= 16'd0;
         prev_valid_ff <= 1'b0;
         armed_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         bits_ff       <= bits_in;
         prev_time_ff  <= prev_time_in;
         prev_valid_ff <= prev_valid_in;
         armed_ff      <= armed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload, loaded with the valid bit
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff  <= emit_status;
         rsp_address_ff <= emit_address;
         rsp_command_ff <= emit_command;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_command = rsp_command_ff;

   // Timeout can only be armed inside a frame
   `NECIR_ASSERT_IMP(a_armed_active, clock, reset, armed_ff, phase_ff != PH_IDLE)
   // A result produced by the stage shows up in the result register
   `NECIR_ASSERT_NXT(a_emit_shown, clock, reset, emit, rsp_valid_ff)
   // Timeout and bad pulse results carry zero bytes
   `NECIR_ASSERT_IMP(a_zero_bytes, clock, reset,
      rsp_valid_ff && (rsp_status_ff == ST_TIMEOUT || rsp_status_ff == ST_BAD_PULSE),
      rsp_address_ff == 8'd0 && rsp_command_ff == 8'd0)

endmodule

// File: rtl/nec_ir_frame_decoder.sv
// Path: a request is accepted into the input register; any result it produces
// is loaded from there into the result register, where it is handed off.
// Throughput: one request per cycle; the input stalls only while a result
// waits in the result register and the output side stalls.
// Reset: clears frame state and handshake valids and reloads the default
// pulse windows into the threshold registers.
module nec_ir_frame_decoder import necir_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_capture_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_address,
   output logic [7:0]  rsp_command,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type     cfg;
   logic        stage_go;
   logic        stage_valid_ff, stage_valid_in;
   logic        stage_action_ff;
   logic [15:0] stage_time_ff;

   necir_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Input register holds while the stage is blocked
   assign req_stall = stage_valid_ff && !stage_go;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (!req_stall) begin
         stage_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_action_ff <= req_action;
         stage_time_ff   <= req_capture_time;
      end
   end

   necir_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .stage_valid  (stage_valid_ff),
      .stage_action (stage_action_ff),
      .stage_time   (stage_time_ff),
      .stage_go     (stage_go),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_address  (rsp_address),
      .rsp_command  (rsp_command)
   );

endmodule
